### hdl/aizawa_pkg.sv
package aizawa_pkg;

   localparam int FRAC_BITS = 24;
   localparam int ACC_W     = 36;
   localparam int DIGIT_W   = 17;
   localparam int DIV3_SH   = DIGIT_W + 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
   localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
   localparam logic [DIV3_SH-1:0] DIV3_MUL = DIV3_SH'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_D    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_E    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_F    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE = 3'd6;

   typedef logic signed [31:0] q_type;
   typedef logic [30:0] step_type;

   typedef struct packed {
      q_type x;
      q_type y;
      q_type z;
   } vec_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] x;
      logic signed [ACC_W-1:0] y;
      logic signed [ACC_W-1:0] z;
   } acc_type;

   // state that rides along the pipeline with each particle
   typedef struct packed {
      vec_type p0;
      logic    last;
      acc_type acc;
   } side_type;

   typedef struct packed {
      q_type    a;
      q_type    b;
      q_type    c;
      q_type    d;
      q_type    e;
      q_type    f;
      step_type h;
   } coef_type;

   typedef struct packed {
      q_type next_x;
      q_type next_y;
      q_type next_z;
      logic  last_out;
   } result_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] q;
      logic [1:0]         r;
   } div3_type;

   // clamp to the 32-bit signed range
   function automatic q_type sat32(input logic signed [63:0] v);
      q_type res;
      if (v > Q_MAX) begin
         res = Q_MAX[31:0];
      end else if (v < Q_MIN) begin
         res = Q_MIN[31:0];
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // round a product by 2^sh, half toward +inf, then saturate
   function automatic q_type round_shift(input logic signed [63:0] p, input int sh);
      logic signed [63:0] half;
      half = 64'sd1 <<< (sh - 1);
      return sat32((p + half) >>> sh);
   endfunction

   // Q8.24 multiply
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [63:0] p;
      p = a * b;
      return round_shift(p, FRAC_BITS);
   endfunction

   // one digit of a long division by 3, using a reciprocal multiply
   function automatic div3_type div3_digit(input logic [1:0] rem,
                                           input logic [DIGIT_W-1:0] digit);
      logic [DIGIT_W+1:0]         v;
      logic [DIGIT_W+DIV3_SH+1:0] prod;
      logic [DIGIT_W+1:0]         back;
      div3_type                   res;
      v     = {rem, digit};
      prod  = (DIGIT_W + DIV3_SH + 2)'(v) * (DIGIT_W + DIV3_SH + 2)'(DIV3_MUL);
      res.q = prod[DIV3_SH+DIGIT_W-1:DIV3_SH];
      back  = {2'b00, res.q} + {1'b0, res.q, 1'b0};
      res.r = 2'(v - back);
      return res;
   endfunction

endpackage

### hdl/aizawa_if.sv
interface aizawa_req_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic        last_particle;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output last_particle, input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input last_particle, output ready);
endinterface

interface aizawa_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [31:0] next_x;
   logic signed [31:0] next_y;
   logic signed [31:0] next_z;
   logic        last_out;

   modport source (output valid, output next_x, output next_y, output next_z,
                   output last_out, input ready);
   modport sink (input valid, input next_x, input next_y, input next_z,
                 input last_out, output ready);
endinterface

### hdl/aizawa_deriv.sv
module aizawa_deriv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  aizawa_pkg::vec_type   pt,
   input  aizawa_pkg::side_type  side_in,
   input  aizawa_pkg::coef_type  coef,
   output logic                  out_valid,
   output aizawa_pkg::vec_type   k,
   output aizawa_pkg::side_type  side_out
);
   import aizawa_pkg::*;

   logic [3:0] valid_ff;

   // stage 1: first-level products
   q_type s1_x_ff, s1_y_ff, s1_z_ff, s1_x2_ff, s1_y2_ff, s1_zz_ff;
   q_type s1_ezp_ff, s1_az_ff, s1_fz_ff, s1_zb_ff, s1_dy_ff, s1_dx_ff;
   side_type s1_side_ff;
   // stage 2: second-level products and sums
   q_type s2_z3_ff, s2_x3_ff, s2_r_ff, s2_ez_ff, s2_k0a_ff, s2_k1b_ff;
   q_type s2_dy_ff, s2_dx_ff, s2_az_ff, s2_fz_ff;
   side_type s2_side_ff;
   // stage 3: last products, x and y components, upper digit of z^3/3
   q_type s3_re_ff, s3_fzx3_ff, s3_kx_ff, s3_ky_ff, s3_az_ff;
   div3_type s3_zhi_ff;
   logic [DIGIT_W-1:0] s3_zlo_ff;
   side_type s3_side_ff;
   // stage 4: z component
   vec_type  s4_k_ff;
   side_type s4_side_ff;

   logic signed [63:0] z3_off;
   logic [2*DIGIT_W-1:0] z3u;
   div3_type zlo_div;
   logic [2*DIGIT_W-1:0] z3q;
   logic signed [63:0] z3d;

   // bias z^3 + 1 to a positive value before dividing by 3
   assign z3_off  = 64'(s2_z3_ff) + 64'sd1 + 64'sd6442450944;
   assign z3u     = z3_off[2*DIGIT_W-1:0];
   assign zlo_div = div3_digit(s3_zhi_ff.r, s3_zlo_ff);
   assign z3q     = {s3_zhi_ff.q, zlo_div.q};
   assign z3d     = $signed(64'(z3q)) - 64'sd2147483648;

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff    <= pt.x;
         s1_y_ff    <= pt.y;
         s1_z_ff    <= pt.z;
         s1_x2_ff   <= qmul(pt.x, pt.x);
         s1_y2_ff   <= qmul(pt.y, pt.y);
         s1_zz_ff   <= qmul(pt.z, pt.z);
         s1_ezp_ff  <= qmul(coef.e, pt.z);
         s1_az_ff   <= qmul(coef.a, pt.z);
         s1_fz_ff   <= qmul(coef.f, pt.z);
         s1_zb_ff   <= sat32(64'(pt.z) - 64'(coef.b));
         s1_dy_ff   <= qmul(coef.d, pt.y);
         s1_dx_ff   <= qmul(coef.d, pt.x);
         s1_side_ff <= side_in;

         s2_z3_ff   <= qmul(s1_zz_ff, s1_z_ff);
         s2_x3_ff   <= qmul(s1_x2_ff, s1_x_ff);
         s2_r_ff    <= sat32(64'(s1_x2_ff) + 64'(s1_y2_ff));
         s2_ez_ff   <= sat32(ONE_Q + 64'(s1_ezp_ff));
         s2_k0a_ff  <= qmul(s1_zb_ff, s1_x_ff);
         s2_k1b_ff  <= qmul(s1_zb_ff, s1_y_ff);
         s2_dy_ff   <= s1_dy_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_az_ff   <= s1_az_ff;
         s2_fz_ff   <= s1_fz_ff;
         s2_side_ff <= s1_side_ff;

         s3_re_ff   <= qmul(s2_r_ff, s2_ez_ff);
         s3_fzx3_ff <= qmul(s2_fz_ff, s2_x3_ff);
         s3_kx_ff   <= sat32(64'(s2_k0a_ff) - 64'(s2_dy_ff));
         s3_ky_ff   <= sat32(64'(s2_dx_ff) + 64'(s2_k1b_ff));
         s3_az_ff   <= s2_az_ff;
         s3_zhi_ff  <= div3_digit(2'b00, z3u[2*DIGIT_W-1:DIGIT_W]);
         s3_zlo_ff  <= z3u[DIGIT_W-1:0];
         s3_side_ff <= s2_side_ff;

         s4_k_ff.x  <= s3_kx_ff;
         s4_k_ff.y  <= s3_ky_ff;
         s4_k_ff.z  <= sat32(64'(coef.c) + 64'(s3_az_ff) - z3d - 64'(s3_re_ff)
                             + 64'(s3_fzx3_ff));
         s4_side_ff <= s3_side_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign k         = s4_k_ff;
   assign side_out  = s4_side_ff;

endmodule

### hdl/aizawa_update.sv
module aizawa_update #(
   parameter int SHIFT        = 25,
   parameter int WEIGHT_SHIFT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  aizawa_pkg::vec_type   k,
   input  aizawa_pkg::side_type  side_in,
   input  aizawa_pkg::step_type  step_h,
   output logic                  out_valid,
   output aizawa_pkg::vec_type   pt,
   output aizawa_pkg::side_type  side_out
);
   import aizawa_pkg::*;

   logic [1:0] valid_ff;
   logic signed [63:0] u1_px_ff, u1_py_ff, u1_pz_ff;
   side_type u1_side_ff;
   side_type side_acc;
   vec_type  u2_pt_ff;
   side_type u2_side_ff;
   q_type    h_s;

   assign h_s = $signed({1'b0, step_h});

   // fold this slope into the weighted sum
   always_comb begin
      side_acc       = side_in;
      side_acc.acc.x = side_in.acc.x + (ACC_W'(k.x) <<< WEIGHT_SHIFT);
      side_acc.acc.y = side_in.acc.y + (ACC_W'(k.y) <<< WEIGHT_SHIFT);
      side_acc.acc.z = side_in.acc.z + (ACC_W'(k.z) <<< WEIGHT_SHIFT);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[0], in_valid};
      end
   end

   // multiply by h, then round and add to the start point
   always_ff @(posedge clock) begin
      if (en) begin
         u1_px_ff   <= h_s * k.x;
         u1_py_ff   <= h_s * k.y;
         u1_pz_ff   <= h_s * k.z;
         u1_side_ff <= side_acc;

         u2_pt_ff.x <= sat32(64'(u1_side_ff.p0.x) + 64'(round_shift(u1_px_ff, SHIFT)));
         u2_pt_ff.y <= sat32(64'(u1_side_ff.p0.y) + 64'(round_shift(u1_py_ff, SHIFT)));
         u2_pt_ff.z <= sat32(64'(u1_side_ff.p0.z) + 64'(round_shift(u1_pz_ff, SHIFT)));
         u2_side_ff <= u1_side_ff;
      end
   end

   assign out_valid = valid_ff[1];
   assign pt        = u2_pt_ff;
   assign side_out  = u2_side_ff;

endmodule

### hdl/aizawa_final.sv
module aizawa_final (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  aizawa_pkg::vec_type    k,
   input  aizawa_pkg::side_type   side_in,
   input  aizawa_pkg::step_type   step_h,
   output logic                   out_valid,
   output aizawa_pkg::result_type res
);
   import aizawa_pkg::*;

   localparam int HI_W  = ACC_W - FRAC_BITS;
   localparam int PH_W  = 31 + HI_W + 1;
   localparam int PL_W  = 31 + FRAC_BITS;
   localparam int W_W   = PH_W + 1;
   localparam int U_W   = 3 * DIGIT_W;
   localparam int INC_W = 43;
   localparam logic signed [U_W-1:0] U_BIAS = U_W'(64'sd3 <<< 42);
   localparam logic signed [63:0]    Q_BIAS = 64'sd1 <<< 42;

   logic [5:0] valid_ff;

   logic signed [ACC_W-1:0] f1_s_ff [3];
   logic signed [PH_W-1:0]  f2_hi_ff [3];
   logic [PL_W-1:0]         f2_lo_ff [3];
   div3_type                f3_d_ff [3];
   logic [2*DIGIT_W-1:0]    f3_rest_ff [3];
   logic [DIGIT_W-1:0]      f4_qtop_ff [3];
   div3_type                f4_d_ff [3];
   logic [DIGIT_W-1:0]      f4_low_ff [3];
   logic signed [INC_W-1:0] f5_inc_ff [3];
   q_type                   f6_next_ff [3];
   side_type f1_side_ff, f2_side_ff, f3_side_ff, f4_side_ff, f5_side_ff;
   logic     f6_last_ff;

   logic signed [ACC_W-1:0] acc_in [3];
   logic signed [ACC_W-1:0] k_in [3];
   q_type                   p0 [3];
   logic signed [W_W-1:0]   w [3];
   logic [U_W-1:0]          u [3];
   div3_type                d_low [3];
   logic [U_W-1:0]          q [3];
   logic signed [63:0]      inc_full [3];
   q_type                   h_s;

   assign h_s = $signed({1'b0, step_h});

   // lane views of the packed structs
   always_comb begin
      acc_in[0] = side_in.acc.x;
      acc_in[1] = side_in.acc.y;
      acc_in[2] = side_in.acc.z;
      k_in[0]   = ACC_W'(k.x);
      k_in[1]   = ACC_W'(k.y);
      k_in[2]   = ACC_W'(k.z);
      p0[0]     = f5_side_ff.p0.x;
      p0[1]     = f5_side_ff.p0.y;
      p0[2]     = f5_side_ff.p0.z;
   end

   // floor(h s / 2^24 + 3) split into two products, then divided by 6
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         w[i] = W_W'(f2_hi_ff[i]) + W_W'(3) + $signed(W_W'(f2_lo_ff[i][PL_W-1:FRAC_BITS]));
         u[i] = U_W'($signed(w[i][W_W-1:1])) + U_BIAS;
         d_low[i]    = div3_digit(f4_d_ff[i].r, f4_low_ff[i]);
         q[i]        = {f4_qtop_ff[i], f4_d_ff[i].q, d_low[i].q};
         inc_full[i] = $signed(64'(q[i])) - Q_BIAS;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            f1_s_ff[i]    <= acc_in[i] + k_in[i];
            f2_hi_ff[i]   <= h_s * $signed(f1_s_ff[i][ACC_W-1:FRAC_BITS]);
            f2_lo_ff[i]   <= PL_W'(step_h) * PL_W'(f1_s_ff[i][FRAC_BITS-1:0]);
            f3_d_ff[i]    <= div3_digit(2'b00, u[i][U_W-1:2*DIGIT_W]);
            f3_rest_ff[i] <= u[i][2*DIGIT_W-1:0];
            f4_qtop_ff[i] <= f3_d_ff[i].q;
            f4_d_ff[i]    <= div3_digit(f3_d_ff[i].r, f3_rest_ff[i][2*DIGIT_W-1:DIGIT_W]);
            f4_low_ff[i]  <= f3_rest_ff[i][DIGIT_W-1:0];
            f5_inc_ff[i]  <= inc_full[i][INC_W-1:0];
            f6_next_ff[i] <= sat32(64'(p0[i]) + 64'(f5_inc_ff[i]));
         end
         f1_side_ff <= side_in;
         f2_side_ff <= f1_side_ff;
         f3_side_ff <= f2_side_ff;
         f4_side_ff <= f3_side_ff;
         f5_side_ff <= f4_side_ff;
         f6_last_ff <= f5_side_ff.last;
      end
   end

   assign out_valid    = valid_ff[5];
   assign res.next_x   = f6_next_ff[0];
   assign res.next_y   = f6_next_ff[1];
   assign res.next_z   = f6_next_ff[2];
   assign res.last_out = f6_last_ff;

endmodule

### hdl/aizawa_outbuf.sv
module aizawa_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  aizawa_pkg::result_type in_res,
   output logic                   en,
   aizawa_rsp_if.source           rsp_if
);
   import aizawa_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_res_ff, out_res_in;
   result_type skid_res_ff, skid_res_in;
   logic       out_free;

   assign out_free = !out_valid_ff || rsp_if.ready;
   assign en       = !skid_valid_ff;

   // drain the skid first; park a transaction there when the output is blocked
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_res_in   = in_res;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.next_x   = out_res_ff.next_x;
   assign rsp_if.next_y   = out_res_ff.next_y;
   assign rsp_if.next_z   = out_res_ff.next_z;
   assign rsp_if.last_out = out_res_ff.last_out;

endmodule

### hdl/aizawa_rk4_step_unit.sv
// One classical RK4 step of the Aizawa system per particle, in signed Q8.24
// with saturation. The unit is a fully pipelined datapath of four derivative
// evaluations of four stages each, three two-stage intermediate-point updates,
// a six-stage final combine with the divide by 6, and the output register. It
// takes one particle every clock cycle unless the output buffer is full.
// Results leave in the order particles came in. A two-entry output buffer
// keeps the input side running while a result waits to be taken, and stalls it
// once both entries are full. Coefficients and the step size are written
// through the csr port and must only change while no particle is in flight.
module aizawa_rk4_step_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [aizawa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [aizawa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   aizawa_req_if.sink                           req_if,
   aizawa_rsp_if.source                         rsp_if
);
   import aizawa_pkg::*;

   coef_type coef_ff;
   logic     en;

   vec_type  pt0;
   side_type side0;

   logic     d1_valid, u1_valid, d2_valid, u2_valid, d3_valid, u3_valid, d4_valid;
   logic     fin_valid;
   vec_type  d1_k, u1_pt, d2_k, u2_pt, d3_k, u3_pt, d4_k;
   side_type d1_side, u1_side, d2_side, u2_side, d3_side, u3_side, d4_side;
   result_type fin_res;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COEF_A:    coef_ff.a <= csr_wdata;
            CSR_COEF_B:    coef_ff.b <= csr_wdata;
            CSR_COEF_C:    coef_ff.c <= csr_wdata;
            CSR_COEF_D:    coef_ff.d <= csr_wdata;
            CSR_COEF_E:    coef_ff.e <= csr_wdata;
            CSR_COEF_F:    coef_ff.f <= csr_wdata;
            CSR_STEP_SIZE: coef_ff.h <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = en;

   // start point and an empty slope sum
   always_comb begin
      pt0.x      = req_if.pos_x;
      pt0.y      = req_if.pos_y;
      pt0.z      = req_if.pos_z;
      side0.p0   = pt0;
      side0.last = req_if.last_particle;
      side0.acc  = '0;
   end

   aizawa_deriv u_deriv1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_if.valid),
      .pt(pt0), .side_in(side0), .coef(coef_ff),
      .out_valid(d1_valid), .k(d1_k), .side_out(d1_side));

   aizawa_update #(.SHIFT(FRAC_BITS + 1), .WEIGHT_SHIFT(0)) u_update1 (
      .clock(clock), .reset(reset), .en(en), .in_valid(d1_valid),
      .k(d1_k), .side_in(d1_side), .step_h(coef_ff.h),
      .out_valid(u1_valid), .pt(u1_pt), .side_out(u1_side));

   aizawa_deriv u_deriv2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(u1_valid),
      .pt(u1_pt), .side_in(u1_side), .coef(coef_ff),
      .out_valid(d2_valid), .k(d2_k), .side_out(d2_side));

   aizawa_update #(.SHIFT(FRAC_BITS + 1), .WEIGHT_SHIFT(1)) u_update2 (
      .clock(clock), .reset(reset), .en(en), .in_valid(d2_valid),
      .k(d2_k), .side_in(d2_side), .step_h(coef_ff.h),
      .out_valid(u2_valid), .pt(u2_pt), .side_out(u2_side));

   aizawa_deriv u_deriv3 (
      .clock(clock), .reset(reset), .en(en), .in_valid(u2_valid),
      .pt(u2_pt), .side_in(u2_side), .coef(coef_ff),
      .out_valid(d3_valid), .k(d3_k), .side_out(d3_side));

   aizawa_update #(.SHIFT(FRAC_BITS), .WEIGHT_SHIFT(1)) u_update3 (
      .clock(clock), .reset(reset), .en(en), .in_valid(d3_valid),
      .k(d3_k), .side_in(d3_side), .step_h(coef_ff.h),
      .out_valid(u3_valid), .pt(u3_pt), .side_out(u3_side));

   aizawa_deriv u_deriv4 (
      .clock(clock), .reset(reset), .en(en), .in_valid(u3_valid),
      .pt(u3_pt), .side_in(u3_side), .coef(coef_ff),
      .out_valid(d4_valid), .k(d4_k), .side_out(d4_side));

   aizawa_final u_final (
      .clock(clock), .reset(reset), .en(en), .in_valid(d4_valid),
      .k(d4_k), .side_in(d4_side), .step_h(coef_ff.h),
      .out_valid(fin_valid), .res(fin_res));

   aizawa_outbuf u_outbuf (
      .clock(clock), .reset(reset), .in_valid(fin_valid), .in_res(fin_res),
      .en(en), .rsp_if(rsp_if));

endmodule

### test/tb.sv
module tb;
   import aizawa_pkg::*;

   localparam int IDLE_MAX   = 17;
   localparam int DRAIN_WAIT = 40;
   localparam int STALL_MAX  = 3000;

   // Q8.24 values of the published attractor coefficients
   localparam logic [31:0] Q_A_NOM = 32'sd15938355;  // 0.95
   localparam logic [31:0] Q_B_NOM = 32'sd11744051;  // 0.7
   localparam logic [31:0] Q_C_NOM = 32'sd10066330;  // 0.6
   localparam logic [31:0] Q_D_NOM = 32'sd58720256;  // 3.5
   localparam logic [31:0] Q_E_NOM = 32'sd4194304;   // 0.25
   localparam logic [31:0] Q_F_NOM = 32'sd1677722;   // 0.1
   localparam logic [31:0] Q_H_NOM = 32'sd167772;    // 0.01
   localparam logic [31:0] Q_ONE   = 32'sd16777216;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   aizawa_req_if req_if ();
   aizawa_rsp_if rsp_if ();

   aizawa_rk4_step_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_if.sink),
      .rsp_if    (rsp_if.source)
   );

   // shadow copy of the coefficient registers
   longint coef_a, coef_b, coef_c, coef_d, coef_e, coef_f, step_h;

   result_type next_states[$];
   int  errors = 0;
   int  particles_sent = 0;
   int  states_checked = 0;
   int  settings_used = 0;
   int  quiet_cycles = 0;
   bit  burst_mode = 0;

   // clock
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // fixed-point prediction of one RK4 step
   // ------------------------------------------------------------------
   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // round v / 2^sh half toward +inf, then clamp
   function automatic longint round_clamp(longint v, int sh);
      longint half;
      half = 64'sd1 <<< (sh - 1);
      return clamp32((v + half) >>> sh);
   endfunction

   function automatic longint fix_mul(longint a, longint b);
      return round_clamp(a * b, FRAC_BITS);
   endfunction

   function automatic longint floor_quot(logic signed [127:0] v, logic signed [127:0] d);
      logic signed [127:0] q;
      q = v / d;
      if ((v % d) != 0 && v < 0) q = q - 1;
      return longint'(q);
   endfunction

   task automatic aizawa_slope(input longint x, input longint y, input longint z,
                               output longint dx, output longint dy, output longint dz);
      longint zb, x2, y2, z3, x3, r2, ez, z3d;
      zb  = clamp32(z - coef_b);
      x2  = fix_mul(x, x);
      y2  = fix_mul(y, y);
      z3  = fix_mul(fix_mul(z, z), z);
      x3  = fix_mul(x2, x);
      r2  = clamp32(x2 + y2);
      ez  = clamp32((64'sd1 <<< FRAC_BITS) + fix_mul(coef_e, z));
      z3d = floor_quot(2 * z3 + 3, 6);
      dx  = clamp32(fix_mul(zb, x) - fix_mul(coef_d, y));
      dy  = clamp32(fix_mul(coef_d, x) + fix_mul(zb, y));
      dz  = clamp32(coef_c + fix_mul(coef_a, z) - z3d - fix_mul(r2, ez)
                    + fix_mul(fix_mul(coef_f, z), x3));
   endtask

   task automatic rk4_advance(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic lastp,
                              output result_type res);
      longint p0[3], pt[3], k1[3], k2[3], k3[3], k4[3], nv[3];
      logic signed [127:0] num;
      p0[0] = longint'($signed(px));
      p0[1] = longint'($signed(py));
      p0[2] = longint'($signed(pz));
      aizawa_slope(p0[0], p0[1], p0[2], k1[0], k1[1], k1[2]);
      for (int i = 0; i < 3; i++) pt[i] = clamp32(p0[i] + round_clamp(step_h * k1[i], 25));
      aizawa_slope(pt[0], pt[1], pt[2], k2[0], k2[1], k2[2]);
      for (int i = 0; i < 3; i++) pt[i] = clamp32(p0[i] + round_clamp(step_h * k2[i], 25));
      aizawa_slope(pt[0], pt[1], pt[2], k3[0], k3[1], k3[2]);
      for (int i = 0; i < 3; i++) pt[i] = clamp32(p0[i] + round_clamp(step_h * k3[i], 24));
      aizawa_slope(pt[0], pt[1], pt[2], k4[0], k4[1], k4[2]);
      // weighted sum kept exact, one rounding of h*s/(6*2^24)
      for (int i = 0; i < 3; i++) begin
         num = 128'(step_h) * 128'(k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i])
               + 128'(3 * (64'sd1 <<< FRAC_BITS));
         nv[i] = clamp32(p0[i] + floor_quot(num, 128'(6 * (64'sd1 <<< FRAC_BITS))));
      end
      res.next_x   = nv[0][31:0];
      res.next_y   = nv[1][31:0];
      res.next_z   = nv[2][31:0];
      res.last_out = lastp;
   endtask

   // ------------------------------------------------------------------
   // register writes, particle sending, draining
   // ------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_COEF_A:    coef_a = longint'($signed(data));
         CSR_COEF_B:    coef_b = longint'($signed(data));
         CSR_COEF_C:    coef_c = longint'($signed(data));
         CSR_COEF_D:    coef_d = longint'($signed(data));
         CSR_COEF_E:    coef_e = longint'($signed(data));
         CSR_COEF_F:    coef_f = longint'($signed(data));
         CSR_STEP_SIZE: step_h = longint'(data[30:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   // write all registers; the caller drops the write enable afterwards
   task automatic write_coefs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d,
                              input logic [31:0] e, input logic [31:0] f,
                              input logic [31:0] h);
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, b);
      write_reg(CSR_COEF_C, c);
      write_reg(CSR_COEF_D, d);
      write_reg(CSR_COEF_E, e);
      write_reg(CSR_COEF_F, f);
      write_reg(CSR_STEP_SIZE, h);
      settings_used++;
   endtask

   task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] pz, input logic lastp);
      int gap;
      result_type res;
      gap = burst_mode ? 0 : $urandom_range(0, IDLE_MAX);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.pos_x         <= px;
      req_if.pos_y         <= py;
      req_if.pos_z         <= pz;
      req_if.last_particle <= lastp;
      do @(posedge clock); while (!req_if.ready);
      rk4_advance(px, py, pz, lastp, res);
      next_states.push_back(res);
      particles_sent++;
   endtask

   // drop valid and wait for the pipeline to empty
   task automatic drain;
      req_if.valid <= 1'b0;
      while (next_states.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // coordinate mostly within the attractor, sometimes any 32-bit value
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2:       return $urandom_range(0, 1) ? 32'h0 : Q_ONE;
         default: return 32'($urandom_range(0, 32'h06000000)) - 32'h03000000;
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      return ($urandom_range(0, 3) == 0) ? $urandom() :
             32'($urandom_range(0, 32'h0a000000)) - 32'h05000000;
   endfunction

   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) burst_mode = ($urandom_range(0, 2) == 0);
         send_particle(rand_coord(), rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
      end
      burst_mode = 0;
   endtask

   task automatic send_corners;
      logic [31:0] corner[6];
      corner = '{32'h0, Q_ONE, -Q_ONE, 32'h7fffffff, 32'h80000000, 32'hffffffff};
      foreach (corner[i]) send_particle(corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6], i[0]);
      send_particle(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1);
      send_particle(32'h80000000, 32'h80000000, 32'h80000000, 1'b0);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset values: all coefficients and the step are zero
   task automatic test_reset_defaults;
      send_corners();
      send_random(8);
      drain();
   endtask

   // nominal attractor with the usual small step
   task automatic test_nominal_attractor;
      write_coefs(Q_A_NOM, Q_B_NOM, Q_C_NOM, Q_D_NOM, Q_E_NOM, Q_F_NOM, Q_H_NOM);
      // unused index must not disturb anything
      write_reg(CSR_UNUSED, 32'hdeadbeef);
      csr_we <= 1'b0;
      send_corners();
      send_particle(32'h00199999, 32'h0, 32'h0, 1'b0);
      send_random(150);
      drain();
   endtask

   // extreme coefficients and the largest step; step bit 31 is masked
   task automatic test_extreme_coefs;
      write_coefs(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'hffffffff);
      csr_we <= 1'b0;
      send_corners();
      send_random(40);
      drain();
      write_coefs(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h80000001);
      csr_we <= 1'b0;
      send_random(40);
      drain();
   endtask

   // several random coefficient sets
   task automatic test_random_coefs;
      for (int s = 0; s < 4; s++) begin
         write_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                     rand_coef(), ($urandom_range(0, 1) ? $urandom() :
                                   32'($urandom_range(0, 32'h01000000))));
         csr_we <= 1'b0;
         send_random(35);
         drain();
      end
   endtask

   // ------------------------------------------------------------------
   // result side: random stalls and checking
   // ------------------------------------------------------------------
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, IDLE_MAX);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && !reset));
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (next_states.size() == 0) begin
            $error("unexpected result x=%0d y=%0d z=%0d", rsp_if.next_x, rsp_if.next_y,
                   rsp_if.next_z);
            errors++;
         end else begin
            want = next_states.pop_front();
            states_checked++;
            if (rsp_if.next_x !== want.next_x) begin
               $error("next_x expected %0d actual %0d", want.next_x, rsp_if.next_x);
               errors++;
            end
            if (rsp_if.next_y !== want.next_y) begin
               $error("next_y expected %0d actual %0d", want.next_y, rsp_if.next_y);
               errors++;
            end
            if (rsp_if.next_z !== want.next_z) begin
               $error("next_z expected %0d actual %0d", want.next_z, rsp_if.next_z);
               errors++;
            end
            if (rsp_if.last_out !== want.last_out) begin
               $error("last_out expected %0b actual %0b", want.last_out, rsp_if.last_out);
               errors++;
            end
         end
      end
   end

   // watchdog: stop when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_MAX) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_if.valid         = 1'b0;
      req_if.pos_x         = '0;
      req_if.pos_y         = '0;
      req_if.pos_z         = '0;
      req_if.last_particle = 1'b0;
      coef_a = 0; coef_b = 0; coef_c = 0; coef_d = 0; coef_e = 0; coef_f = 0;
      step_h = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_nominal_attractor();
      test_extreme_coefs();
      test_random_coefs();

      $display("Stepped %0d particles, checked %0d results under %0d coefficient sets",
               particles_sent, states_checked, settings_used + 1);
      $display("including reset defaults, saturating extremes and random stalls.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
